// File: hw/rtl/ksort_pkg.sv
// Shared constants for the key/payload insertion sorter.
// No dependencies; imported by the top level.
package ksort_pkg;

  // Fixed field widths of the ports
  localparam int KEY_W      = 32;
  localparam int TAG_PORT_W = 16;

  // Sequencer state codes
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] S_SHIFT = 3'd1;
  localparam logic [ST_W-1:0] S_PLACE = 3'd2;
  localparam logic [ST_W-1:0] S_OUT   = 3'd3;
  localparam logic [ST_W-1:0] S_DRAIN = 3'd4;

endpackage

// File: hw/rtl/ksort_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ksort_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/key_payload_insertion_sorter.sv
// Insertion sorter for signed keys with payload tags, store held in one RAM.
// Depends on ksort_pkg and ksort_ram.
//
// Usage:
//   Input: drive in_key, in_tag, in_end_of_run with start high; the beat is
//   taken at a rising edge where start is high and busy is low.
//   Insertion walks the store from the top down through the RAM read port,
//   shifting each strictly greater entry up by one slot, one entry at a time
//   as the RAM has a single read port. A beat into an empty or full store is
//   written or dropped in idle, so busy stays low unless in_end_of_run
//   starts the readout; any other beat keeps busy high until the walk has
//   placed it, also when it lands on top or in slot 0.
//   On a beat with in_end_of_run set, after insertion the store is read out
//   in ascending order while busy: the first read is issued, then N result
//   beats follow on consecutive cycles. The store is emptied and busy drops
//   right after the last beat.
//   Output: each result is shown for one cycle with out_valid high; the
//   receiver cannot stall, so results stream without gaps. out_last_out
//   marks the final beat and out_dropped reports a drop during the run.
//   Entries arriving while the store holds MAX_ENTRIES are dropped.
//   Reset: synchronous, active low; empties the store (fill count and drop
//   flag cleared). No clearing pass: slots above the fill count are unread.
module key_payload_insertion_sorter #(
  parameter int MAX_ENTRIES = 64,
  parameter int TAG_BITS    = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ksort_pkg::KEY_W-1:0]   in_key,
  input  logic [ksort_pkg::TAG_PORT_W-1:0]     in_tag,
  input  logic                                 in_end_of_run,
  output logic                                 out_valid,
  output logic signed [ksort_pkg::KEY_W-1:0]   out_sorted_key,
  output logic [ksort_pkg::TAG_PORT_W-1:0]     out_sorted_tag,
  output logic                                 out_last_out,
  output logic                                 out_dropped
);
  import ksort_pkg::*;

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  // stored tag bits: only the low min(TAG_BITS, 16) bits of the 16-bit port survive
  localparam int TW    = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
  localparam int EW    = KEY_W + TW;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  logic [ST_W-1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [AW-1:0]           rd_cnt_r, rd_cnt_nxt;
  logic signed [KEY_W-1:0] new_key_r, new_key_nxt;
  logic [TW-1:0]           new_tag_r, new_tag_nxt;
  logic                    eor_r, eor_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [EW-1:0]           ram_rdata;

  logic [CNT_W-1:0]        fill_m1;
  logic signed [KEY_W-1:0] q_key;
  logic [TW-1:0]           q_tag;
  logic                    q_greater;

  ksort_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign fill_m1   = fill_r - CNT_W'(1);
  assign q_key     = ram_rdata[EW-1:TW];
  assign q_tag     = ram_rdata[TW-1:0];
  assign q_greater = q_key > new_key_r;

  // sequencer: insertion walk (or drop when full), then readout at end of run
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    ovf_nxt      = ovf_r;
    pos_nxt      = pos_r;
    rd_cnt_nxt   = rd_cnt_r;
    new_key_nxt  = new_key_r;
    new_tag_nxt  = new_tag_r;
    eor_nxt      = eor_r;
    out_vld_nxt  = 1'b0;
    out_last_nxt = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = {new_key_r, new_tag_r};
    ram_raddr    = fill_m1[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          new_key_nxt = in_key;
          new_tag_nxt = in_tag[TW-1:0];
          eor_nxt     = in_end_of_run;
          rd_cnt_nxt  = '0;
          if (fill_r == MAX_CNT) begin
            // store full: drop the entry
            ovf_nxt = 1'b1;
            if (in_end_of_run) begin
              state_nxt = S_OUT;
            end
          end else if (fill_r == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {in_key, in_tag[TW-1:0]};
            fill_nxt  = CNT_W'(1);
            if (in_end_of_run) begin
              state_nxt = S_OUT;
            end
          end else begin
            // fetch the top entry, candidate slot is one above it
            ram_raddr = fill_m1[AW-1:0];
            pos_nxt   = fill_r[AW-1:0];
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        if (q_greater) begin
          // move the greater entry up one slot
          ram_wdata = ram_rdata;
          if (pos_r == AW'(1)) begin
            pos_nxt   = '0;
            state_nxt = S_PLACE;
          end else begin
            ram_raddr = pos_r - AW'(1) - AW'(1);
            pos_nxt   = pos_r - AW'(1);
          end
        end else begin
          ram_wdata = {new_key_r, new_tag_r};
          fill_nxt  = fill_r + CNT_W'(1);
          state_nxt = eor_r ? S_OUT : S_IDLE;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {new_key_r, new_tag_r};
        fill_nxt  = fill_r + CNT_W'(1);
        state_nxt = eor_r ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        // stream reads 0..fill-1, strobe follows read latency
        ram_raddr    = rd_cnt_r;
        rd_cnt_nxt   = rd_cnt_r + AW'(1);
        out_vld_nxt  = 1'b1;
        out_last_nxt = (rd_cnt_r == fill_m1[AW-1:0]);
        if (rd_cnt_r == fill_m1[AW-1:0]) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last beat is on the ports now; empty the store
        fill_nxt  = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      ovf_r      <= 1'b0;
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      ovf_r      <= ovf_nxt;
      out_vld_r  <= out_vld_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    new_key_r <= new_key_nxt;
    new_tag_r <= new_tag_nxt;
    eor_r     <= eor_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_vld_r;
  assign out_sorted_key = q_key;
  assign out_sorted_tag = TAG_PORT_W'(q_tag);
  assign out_last_out   = out_last_r;
  assign out_dropped    = ovf_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= MAX_CNT)
    else $error("fill count beyond capacity");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (state_r == S_OUT || state_r == S_DRAIN))
    else $error("result strobe outside readout");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_last_r) |=> (state_r == S_IDLE && fill_r == '0 && !ovf_r))
    else $error("store not emptied after last beat");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT || state_r == S_OUT) |-> fill_r != '0)
    else $error("store walk with empty store");

endmodule
